FILE: sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Item command codes, and the command and status bundles shared by the DDA
// line rasterizer controller, datapath and top level.
// ----------------------------------------------------------------------------
package dda_pkg;

   // Item command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture endpoints, start point and divider operands
      logic tick;      // advance accumulators by one step and emit the point
      logic div_step;  // run one iteration of the increment dividers
   } dda_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic zero_len;  // endpoints at the input are equal
      logic div_last;  // current divider iteration is the final one
      logic last_step; // next tick produces the end point
   } dda_sts_type;

endpackage

FILE: sv/dda_ctrl.sv
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer for the DDA line rasterizer: handshakes, line state and the
// result valid flag.
// ----------------------------------------------------------------------------
module dda_ctrl
   import dda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dda_sts_type sts,
   output dda_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_ACTIVE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // Take a new item when the result slot frees up and no division runs
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && (state_ff != ST_DIVIDE);
   assign accept    = req_valid && req_ready;

   assign cmd.load     = accept && (req_command == CMD_LOAD);
   assign cmd.tick     = accept && (req_command == CMD_TICK) && (state_ff == ST_ACTIVE);
   assign cmd.div_step = (state_ff == ST_DIVIDE);

   // Next line state; a load drops any line in progress
   always_comb begin
      state_in = state_ff;
      if (cmd.load) begin
         state_in = sts.zero_len ? ST_IDLE : ST_DIVIDE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            ST_DIVIDE: begin
               if (sts.div_last) begin
                  state_in = ST_ACTIVE;
               end
            end
            ST_ACTIVE: begin
               if (cmd.tick && sts.last_step) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Raise valid on a produced point, drop it once the item is taken
   always_comb begin
      priority if (cmd.load || cmd.tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/dda_datapath.sv
// ----------------------------------------------------------------------------
// dda_datapath
// Endpoint deltas, two restoring dividers for the increments, fixed-point
// accumulators with round-half-up and saturation, and the result register.
// ----------------------------------------------------------------------------
module dda_datapath
   import dda_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] x_start,
   input  logic [COORD_BITS-1:0] y_start,
   input  logic [COORD_BITS-1:0] x_end,
   input  logic [COORD_BITS-1:0] y_end,
   input  dda_cmd_type           cmd,
   output dda_sts_type           sts,
   output logic [COORD_BITS-1:0] point_x,
   output logic [COORD_BITS-1:0] point_y,
   output logic                  last_point
);

   localparam int ACC_W = COORD_BITS + 1 + FRAC_BITS;  // signed accumulator
   localparam int Q_W   = FRAC_BITS + 1;               // quotient magnitude
   localparam int INC_W = FRAC_BITS + 2;               // signed increment
   localparam int REM_W = COORD_BITS + 1;              // divider remainder
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
   localparam logic [ACC_W:0]   HALF_FIX = (ACC_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS-1:0]      ax, ay, steps;

   logic signed [ACC_W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [INC_W-1:0] inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [COORD_BITS-1:0]   steps_ff, steps_left_ff, steps_left_in;
   logic [REM_W-1:0]        rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [Q_W-1:0]          quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic                    neg_x_ff, neg_y_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [COORD_BITS-1:0]   point_x_ff, point_y_ff;
   logic                    last_ff;

   logic                    bit_x, bit_y;
   logic [REM_W-1:0]        diff_x, diff_y;

   // Round half up and clamp to the coordinate range
   function automatic logic [COORD_BITS-1:0] round_point(logic signed [ACC_W-1:0] acc);
      logic [ACC_W:0]      v;
      logic [COORD_BITS:0] r;
      v = {acc[ACC_W-1], acc} + HALF_FIX;
      r = v[ACC_W-1:FRAC_BITS];
      if (v[ACC_W]) begin
         return '0;
      end else if (r[COORD_BITS]) begin
         return COORD_MAX;
      end else begin
         return r[COORD_BITS-1:0];
      end
   endfunction

   // Deltas and step count of the line at the input
   assign dx    = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
   assign dy    = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
   assign ax    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
   assign ay    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
   assign steps = (ax > ay) ? ax : ay;

   // One restoring divider iteration per axis
   assign bit_x  = (rem_x_ff >= {1'b0, steps_ff});
   assign bit_y  = (rem_y_ff >= {1'b0, steps_ff});
   assign diff_x = bit_x ? (rem_x_ff - {1'b0, steps_ff}) : rem_x_ff;
   assign diff_y = bit_y ? (rem_y_ff - {1'b0, steps_ff}) : rem_y_ff;

   always_comb begin
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      quo_x_in = quo_x_ff;
      quo_y_in = quo_y_ff;
      cnt_in   = cnt_ff;
      inc_x_in = inc_x_ff;
      inc_y_in = inc_y_ff;
      priority if (cmd.load) begin
         rem_x_in = {1'b0, ax};
         rem_y_in = {1'b0, ay};
         quo_x_in = '0;
         quo_y_in = '0;
         cnt_in   = '0;
         inc_x_in = '0;
         inc_y_in = '0;
      end else if (cmd.div_step) begin
         rem_x_in = {diff_x[REM_W-2:0], 1'b0};
         rem_y_in = {diff_y[REM_W-2:0], 1'b0};
         quo_x_in = {quo_x_ff[Q_W-2:0], bit_x};
         quo_y_in = {quo_y_ff[Q_W-2:0], bit_y};
         cnt_in   = cnt_ff + 1'b1;
         // Apply the delta sign once the final quotient bit is in
         if (cnt_ff == CNT_LAST) begin
            inc_x_in = neg_x_ff ? -$signed({1'b0, quo_x_in}) : $signed({1'b0, quo_x_in});
            inc_y_in = neg_y_ff ? -$signed({1'b0, quo_y_in}) : $signed({1'b0, quo_y_in});
         end
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Advance accumulators on a tick, seed them on a load
   always_comb begin
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      steps_left_in = steps_left_ff;
      priority if (cmd.load) begin
         acc_x_in      = {1'b0, x_start, {FRAC_BITS{1'b0}}};
         acc_y_in      = {1'b0, y_start, {FRAC_BITS{1'b0}}};
         steps_left_in = steps;
      end else if (cmd.tick) begin
         acc_x_in      = acc_x_ff + {{(ACC_W-INC_W){inc_x_ff[INC_W-1]}}, inc_x_ff};
         acc_y_in      = acc_y_ff + {{(ACC_W-INC_W){inc_y_ff[INC_W-1]}}, inc_y_ff};
         steps_left_in = steps_left_ff - 1'b1;
      end else begin
         steps_left_in = steps_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         inc_x_ff      <= '0;
         inc_y_ff      <= '0;
         steps_left_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         inc_x_ff      <= inc_x_in;
         inc_y_ff      <= inc_y_in;
         steps_left_ff <= steps_left_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Divider operands and signs
   always_ff @(posedge clock) begin
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      if (cmd.load) begin
         steps_ff <= steps;
         neg_x_ff <= dx[COORD_BITS];
         neg_y_ff <= dy[COORD_BITS];
      end
   end

   // Result register: start point on load, rounded point on tick
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         point_x_ff <= x_start;
         point_y_ff <= y_start;
         last_ff    <= (steps == '0);
      end else if (cmd.tick) begin
         point_x_ff <= round_point(acc_x_in);
         point_y_ff <= round_point(acc_y_in);
         last_ff    <= (steps_left_ff == COORD_BITS'(1));
      end
   end

   assign sts.zero_len  = (steps == '0);
   assign sts.div_last  = (cnt_ff == CNT_LAST);
   assign sts.last_step = (steps_left_ff == COORD_BITS'(1));

   assign point_x    = point_x_ff;
   assign point_y    = point_y_ff;
   assign last_point = last_ff;

endmodule

FILE: sv/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer with load and tick commands on one valid/ready channel.
// ----------------------------------------------------------------------------
// A load item (command 0) captures two endpoints and returns the start point
// in the next cycle, flagged as last when the line has zero length. For a line
// of nonzero length the block then runs the two restoring dividers that form
// the x and y increments (one quotient bit per cycle), with req_ready low.
// Then each tick item (command 1) is taken one per cycle unless the response
// side stalls, and returns the next point, rounded half up, with last_point
// set on the end point. A tick with no line in progress is taken and gives no
// result. A load while a line is in progress drops that line.
module dda_line_rasterizer
   import dda_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_point_x,
   output logic [COORD_BITS-1:0] rsp_point_y,
   output logic                  rsp_last_point
);

   dda_cmd_type cmd;
   dda_sts_type sts;

   dda_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   dda_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .x_start    (req_x_start),
      .y_start    (req_y_start),
      .x_end      (req_x_end),
      .y_end      (req_y_end),
      .cmd        (cmd),
      .sts        (sts),
      .point_x    (rsp_point_x),
      .point_y    (rsp_point_y),
      .last_point (rsp_last_point)
   );

   // A load always produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.load |=> rsp_valid)
      else $error("load gave no result");

   // The final tick of a line produces a point flagged as last
   assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && sts.last_step) |=> (rsp_valid && rsp_last_point))
      else $error("end point not flagged");

   // No item is taken while the dividers run
   assert property (@(posedge clock) disable iff (reset) cmd.div_step |-> !req_ready)
      else $error("item accepted during division");

   // Never issue a load and a tick together
   assert property (@(posedge clock) disable iff (reset) !(cmd.load && cmd.tick))
      else $error("load and tick issued together");

endmodule

FILE: sim/tb_dda_line_rasterizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking testbench for the DDA line rasterizer.
// ----------------------------------------------------------------------------
// Drives load and tick items on the request channel and keeps its own model of
// the accumulators, increments and step counter to predict every plotted
// point. Each point on the response channel is compared field by field with
// the oldest prediction. Directed lines cover zero-length lines, the corners
// of the coordinate range, reloads during a line and ticks with no line in
// progress. Random lines follow, mostly short and fully stepped, mixed with
// truncated lines, extra ticks and noise, under several idle and stall mixes,
// and one long line is stepped to its end point and one tick beyond.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer
   import dda_pkg::*;
();

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + 1 + FRAC_BITS;
   localparam int INC_BITS   = FRAC_BITS + 2;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   localparam int STALL_LIMIT = 2000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } point_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   logic      req_command;
   coord_type req_x_start;
   coord_type req_y_start;
   coord_type req_x_end;
   coord_type req_y_end;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_point_x;
   coord_type rsp_point_y;
   logic      rsp_last_point;

   // Line model state
   logic signed [ACC_BITS-1:0] model_x_acc;
   logic signed [ACC_BITS-1:0] model_y_acc;
   logic signed [INC_BITS-1:0] model_x_inc;
   logic signed [INC_BITS-1:0] model_y_inc;
   logic [COORD_BITS:0]        model_steps_left;
   logic                       model_active;

   point_type expected_points[$];

   int error_count;
   int quiet_cycles;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit handshake_seen;

   dda_line_rasterizer #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_x_start   (req_x_start),
      .req_y_start   (req_y_start),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_last_point(rsp_last_point)
   );

   always #10 clock = ~clock;

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int line_steps(input int xs, input int ys, input int xe, input int ye);
      int ax;
      int ay;
      ax = abs_int(xe - xs);
      ay = abs_int(ye - ys);
      return (ax > ay) ? ax : ay;
   endfunction

   // Magnitude truncated toward zero, sign applied afterwards
   function automatic logic signed [INC_BITS-1:0] step_increment(input int d, input int steps);
      int mag;
      mag = (abs_int(d) << FRAC_BITS) / steps;
      return INC_BITS'((d < 0) ? -mag : mag);
   endfunction

   // Round half up, then clamp to the coordinate range
   function automatic coord_type round_coord(input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS:0] v;
      logic [ACC_BITS-FRAC_BITS:0] r;
      v = {acc[ACC_BITS-1], acc} + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
      if (v < 0) begin
         return '0;
      end
      r = v[ACC_BITS:FRAC_BITS];
      return (r > COORD_MAX) ? coord_type'(COORD_MAX) : coord_type'(r);
   endfunction

   // Advance the line model by one accepted item and queue the point it plots
   task automatic advance_line_model(input logic cmd, input coord_type xs, input coord_type ys,
                                     input coord_type xe, input coord_type ye);
      int        steps;
      point_type p;
      if (cmd == CMD_LOAD) begin
         steps = line_steps(int'(xs), int'(ys), int'(xe), int'(ye));
         model_x_acc = {1'b0, xs, {FRAC_BITS{1'b0}}};
         model_y_acc = {1'b0, ys, {FRAC_BITS{1'b0}}};
         if (steps == 0) begin
            model_x_inc = '0;
            model_y_inc = '0;
            model_steps_left = '0;
            model_active = 1'b0;
         end else begin
            model_x_inc = step_increment(int'(xe) - int'(xs), steps);
            model_y_inc = step_increment(int'(ye) - int'(ys), steps);
            model_steps_left = (COORD_BITS + 1)'(steps);
            model_active = 1'b1;
         end
         p.x = xs;
         p.y = ys;
         p.last = !model_active;
         expected_points.push_back(p);
      end else if (model_active) begin
         model_x_acc = model_x_acc + model_x_inc;
         model_y_acc = model_y_acc + model_y_inc;
         model_steps_left = model_steps_left - 1'b1;
         if (model_steps_left == 0) begin
            model_active = 1'b0;
         end
         p.x = round_coord(model_x_acc);
         p.y = round_coord(model_y_acc);
         p.last = !model_active;
         expected_points.push_back(p);
      end
   endtask

   // Predict on accepted requests, check accepted points, watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         handshake_seen = 1'b0;
         if (req_valid && req_ready) begin
            advance_line_model(req_command, req_x_start, req_y_start, req_x_end, req_y_end);
            handshake_seen = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin : check_point
            point_type p;
            handshake_seen = 1'b1;
            if (expected_points.size() == 0) begin
               $display("time %0t: unexpected point (%0d, %0d) last %0b", $time,
                        rsp_point_x, rsp_point_y, rsp_last_point);
               error_count++;
            end else begin
               p = expected_points.pop_front();
               if (rsp_point_x !== p.x) begin
                  $display("time %0t: point_x expected %0d, actual %0d", $time,
                           p.x, rsp_point_x);
                  error_count++;
               end
               if (rsp_point_y !== p.y) begin
                  $display("time %0t: point_y expected %0d, actual %0d", $time,
                           p.y, rsp_point_y);
                  error_count++;
               end
               if (rsp_last_point !== p.last) begin
                  $display("time %0t: last_point expected %0b, actual %0b", $time,
                           p.last, rsp_last_point);
                  error_count++;
               end
            end
         end
         quiet_cycles = handshake_seen ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Offer one item, idling first at random, and hold it until accepted
   task automatic send_item(input logic cmd, input coord_type xs, input coord_type ys,
                            input coord_type xe, input coord_type ye);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Tick with random content in the ignored endpoint fields
   task automatic send_tick();
      send_item(CMD_TICK, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_tick();
   endtask

   // Drop valid and hold off until every predicted point has come back
   task automatic drain_points();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_tick();
      send_item(CMD_LOAD, '0, '0, '0, '0);
      send_item(CMD_LOAD, coord_type'(COORD_MAX), coord_type'(COORD_MAX),
                coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      send_tick();
      send_item(CMD_LOAD, '0, coord_type'(COORD_MAX), coord_type'(COORD_MAX), '0);
      send_ticks(3);
      // reload while a line is in progress
      send_item(CMD_LOAD, coord_type'(COORD_MAX), '0, '0, coord_type'(COORD_MAX));
      send_ticks(2);
      send_item(CMD_LOAD, coord_type'(5), coord_type'(5), coord_type'(8), coord_type'(3));
      send_ticks(4);
      send_item(CMD_LOAD, coord_type'(20), coord_type'(10), coord_type'(16),
                coord_type'(17));
      send_ticks(8);
   endtask

   // Mostly short lines stepped to the end, with truncation, overrun and noise
   task automatic test_random_lines(input int item_target);
      int     counted;
      int     roll;
      int     span;
      int     steps;
      int     n_ticks;
      int     extra;
      int     xs;
      int     ys;
      int     xe;
      int     ye;
      logic   cmd;
      counted = 0;
      while (counted < item_target) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            cmd = 1'($urandom_range(1));
            send_item(cmd, coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
            if (cmd == CMD_LOAD) counted++;
         end else begin
            roll = $urandom_range(99);
            span = (roll < 4) ? COORD_MAX : (roll < 14) ? 64 : 12;
            xs = $urandom_range(COORD_MAX);
            ys = $urandom_range(COORD_MAX);
            xe = $urandom_range((xs > span) ? xs - span : 0,
                                (xs + span < COORD_MAX) ? xs + span : COORD_MAX);
            ye = $urandom_range((ys > span) ? ys - span : 0,
                                (ys + span < COORD_MAX) ? ys + span : COORD_MAX);
            steps = line_steps(xs, ys, xe, ye);
            send_item(CMD_LOAD, coord_type'(xs), coord_type'(ys), coord_type'(xe),
                      coord_type'(ye));
            counted++;
            n_ticks = steps;
            roll = $urandom_range(99);
            if (roll < 15) n_ticks = $urandom_range(steps);
            if (span == COORD_MAX && n_ticks > 20) n_ticks = $urandom_range(20);
            extra = (roll >= 85) ? $urandom_range(2, 1) : 0;
            send_ticks(n_ticks);
            counted += n_ticks;
            send_ticks(extra);
         end
      end
   endtask

   // One long line, stepped to its end point and one tick beyond
   task automatic test_long_line();
      send_item(CMD_LOAD, '0, coord_type'(3), coord_type'(90), coord_type'(62));
      send_ticks(91);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_LOAD;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end = '0;
      req_y_end = '0;
      rsp_ready = 1'b0;
      error_count = 0;
      quiet_cycles = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      model_x_acc = '0;
      model_y_acc = '0;
      model_x_inc = '0;
      model_y_inc = '0;
      model_steps_left = '0;
      model_active = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();

      test_random_lines(70);

      sender_idle_pct = 48;
      test_random_lines(70);

      drain_points();
      sender_idle_pct = 0;
      receiver_stall_pct = 48;
      test_random_lines(70);

      sender_idle_pct = 29;
      receiver_stall_pct = 29;
      test_random_lines(70);
      test_long_line();

      // Let the last points drain, then allow the block to settle
      drain_points();
      repeat (FRAC_BITS + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/dda_pkg.sv
sv/dda_ctrl.sv
sv/dda_datapath.sv
sv/dda_line_rasterizer.sv
sim/tb_dda_line_rasterizer.sv
